@@ rtl/core/hdp_pkg.sv @@
// ----------------------------------------------------------------------------
// hdp_pkg
// shared types, codes and name tables for the response body deframer
// ----------------------------------------------------------------------------
package hdp_pkg;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_CLOSED_HDR   = 3'd1,
    ERR_HDR_LONG     = 3'd2,
    ERR_REDIRECT     = 3'd3,
    ERR_NO_LOCATION  = 3'd4,
    ERR_STATUS       = 3'd5,
    ERR_CLOSED_CHUNK = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_COUNTED  = 3'd1,
    PH_TO_CLOSE = 3'd2,
    PH_SIZE     = 3'd3,
    PH_DATA     = 3'd4,
    PH_SKIP     = 3'd5,
    PH_END      = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    VS_IDLE      = 3'd0,
    VS_TE_BLANK  = 3'd1,
    VS_TE_MATCH  = 3'd2,
    VS_CL_BLANK  = 3'd3,
    VS_CL_DIGITS = 3'd4
  } vstate_t;

  localparam int unsigned LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'd65536;
  localparam logic [31:0] TERMINATOR = 32'h0D0A0D0A;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [0:7][7:0]  LOC_NAME = "location";
  localparam logic [0:16][7:0] TE_NAME  = "transfer-encoding";
  localparam logic [0:13][7:0] CL_NAME  = "content-length";
  localparam logic [0:6][7:0]  CHUNKED  = "chunked";

  // header scanner state
  typedef struct packed {
    logic       at_line_start;
    logic [4:0] name_match_pos;
    logic [2:0] name_candidates;
    vstate_t    value_state;
    logic [2:0] found_flags;
    logic       is_chunked;
    logic [2:0] chunked_match_pos;
    logic       length_negative;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    at_line_start: 1'b1, name_match_pos: 5'd0, name_candidates: 3'b111,
    value_state: VS_IDLE, found_flags: 3'b000, is_chunked: 1'b0,
    chunked_match_pos: 3'd0, length_negative: 1'b0};

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

@@ rtl/core/hdp_scan.sv @@
// ----------------------------------------------------------------------------
// hdp_scan
// header line scanner: name matching and value parsing for one header byte
// ----------------------------------------------------------------------------
module hdp_scan (
  input  logic [7:0]          data_byte,
  input  hdp_pkg::scan_state_t cur,
  output hdp_pkg::scan_state_t nxt,
  output logic                cl_digit_en,
  output logic [3:0]          cl_digit
);
  import hdp_pkg::*;

  logic [7:0] lb;
  logic [2:0] cand;
  logic [4:0] pos;
  logic [2:0] keep;
  logic [2:0] hit;
  logic [2:0] mpos;
  logic       te_go;

  assign lb       = to_lower(data_byte);
  assign cl_digit = data_byte[3:0];

  always_comb begin
    nxt         = cur;
    cl_digit_en = 1'b0;
    cand        = cur.name_candidates;
    pos         = cur.name_match_pos;
    keep        = 3'b000;
    hit         = 3'b000;
    mpos        = cur.chunked_match_pos;
    te_go       = 1'b0;
    if (data_byte == CH_LF) begin
      nxt.at_line_start   = 1'b1;
      nxt.name_candidates = 3'b000;
      nxt.value_state     = VS_IDLE;
    end else begin
      if (cur.at_line_start) begin
        nxt.at_line_start = 1'b0;
        cand = 3'b111;
        pos  = 5'd0;
      end
      if (cand != 3'b000) begin
        // location
        if (cand[0]) begin
          if (pos < 5'd8) keep[0] = (lb == LOC_NAME[pos[2:0]]);
          else if (pos == 5'd8) hit[0] = (data_byte == 8'h3A);
        end
        // transfer-encoding
        if (cand[1]) begin
          if (pos < 5'd17) keep[1] = (lb == TE_NAME[pos]);
          else if (pos == 5'd17) hit[1] = (data_byte == 8'h3A);
        end
        // content-length
        if (cand[2]) begin
          if (pos < 5'd14) keep[2] = (lb == CL_NAME[pos[3:0]]);
          else if (pos == 5'd14) hit[2] = (data_byte == 8'h3A);
        end
        if (hit != 3'b000) begin
          nxt.name_candidates = 3'b000;
          if ((cur.found_flags & hit) == 3'b000) begin
            nxt.found_flags = cur.found_flags | hit;
            if (hit[1]) nxt.value_state = VS_TE_BLANK;
            else if (hit[2]) nxt.value_state = VS_CL_BLANK;
            else nxt.value_state = VS_IDLE;
          end
        end else begin
          nxt.name_candidates = keep;
        end
        nxt.name_match_pos = (pos < 5'd31) ? pos + 5'd1 : pos;
      end else begin
        case (cur.value_state)
          VS_TE_BLANK: begin
            if (!(data_byte == 8'h20 || data_byte == 8'h09)) begin
              mpos  = 3'd0;
              te_go = 1'b1;
            end
          end
          VS_TE_MATCH: te_go = 1'b1;
          VS_CL_BLANK: begin
            if (data_byte == 8'h20 || data_byte == 8'h09 ||
                data_byte == 8'h0B || data_byte == 8'h0C) begin
              nxt.value_state = VS_CL_BLANK;
            end else if (data_byte == 8'h2B) begin
              nxt.value_state = VS_CL_DIGITS;
            end else if (data_byte == 8'h2D) begin
              nxt.length_negative = 1'b1;
              nxt.value_state     = VS_CL_DIGITS;
            end else if (is_digit(data_byte)) begin
              cl_digit_en     = 1'b1;
              nxt.value_state = VS_CL_DIGITS;
            end else begin
              nxt.value_state = VS_IDLE;
            end
          end
          VS_CL_DIGITS: begin
            if (is_digit(data_byte)) cl_digit_en = 1'b1;
            else nxt.value_state = VS_IDLE;
          end
          default: nxt.value_state = VS_IDLE;
        endcase
        if (te_go) begin
          if (mpos < 3'd7 && lb == CHUNKED[mpos]) begin
            nxt.chunked_match_pos = mpos + 3'd1;
            if (mpos == 3'd6) begin
              nxt.is_chunked  = 1'b1;
              nxt.value_state = VS_IDLE;
            end else begin
              nxt.value_state = VS_TE_MATCH;
            end
          end else begin
            nxt.chunked_match_pos = mpos;
            nxt.value_state       = VS_IDLE;
          end
        end
      end
    end
  end

endmodule

@@ rtl/core/http_response_body_deframer.sv @@
// ----------------------------------------------------------------------------
// http_response_body_deframer
// parses an http response byte stream and emits the body bytes and a verdict
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  input     in_valid/in_ready, command, data_byte          in
//  result    out_valid/out_ready, out_kind, body_byte,      out
//            last_byte, status_code, error_code
//  config    psel, penable, pwrite, paddr, pwdata, prdata   apb slave
//
//  one transfer per cycle while in_ready is high: each byte is processed in the
//  cycle it is accepted and its result (if any) appears in the output register the next cycle.
//  in_ready is high whenever the output register is empty or being drained.
//  synchronous reset returns the parser to the header phase and the header
//  limit to 65536; restart command clears everything but the limit.
module http_response_body_deframer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  body_byte,
  output logic        last_byte,
  output logic [9:0]  status_code,
  output logic [2:0]  error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hdp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // config register
  logic [LIMIT_W-1:0] header_limit;
  logic [LIMIT_W-1:0] limit;

  // parser state
  phase_t                  phase, phase_next;
  logic [31:0]             terminator_window, terminator_window_next;
  logic [LIMIT_W-1:0]      header_count, header_count_next;
  scan_state_t             scan, scan_next, scan_out;
  logic [9:0]              status_value, status_value_next;
  logic                    status_digits_done, status_digits_done_next;
  logic [LENGTH_BITS-1:0]  body_remaining, body_remaining_next;
  logic [LENGTH_BITS-1:0]  chunk_size, chunk_size_next;
  logic                    hex_active, hex_active_next;
  logic [1:0]              crlf_skip, crlf_skip_next;

  logic       res_en;
  kind_t      res_kind;
  logic [7:0] res_byte;
  logic       res_last;
  logic [9:0] res_status;
  err_t       res_err;

  logic                   accept;
  logic                   cl_digit_en;
  logic [3:0]             cl_digit;
  logic [LENGTH_BITS+3:0] dec_sum;
  logic [LENGTH_BITS-1:0] dec_val;
  logic [13:0]            st_sum;
  logic [9:0]             st_end;
  logic [LENGTH_BITS-1:0] rem_dec, chunk_dec;
  logic [3:0]             hex_d;
  logic                   hex_ok;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {{(32-LIMIT_W){1'b0}}, header_limit} : 32'd0;
  assign limit    = (header_limit > LIMIT_MAX) ? LIMIT_MAX : header_limit;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= LIMIT_MAX;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      header_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  hdp_scan u_scan (
    .data_byte   (data_byte),
    .cur         (scan),
    .nxt         (scan_out),
    .cl_digit_en (cl_digit_en),
    .cl_digit    (cl_digit)
  );

  // content-length accumulate, saturating
  assign dec_sum = ({4'd0, body_remaining} << 3) + ({4'd0, body_remaining} << 1)
                 + {{LENGTH_BITS{1'b0}}, cl_digit};
  assign dec_val = (dec_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX
                 : dec_sum[LENGTH_BITS-1:0];
  // status digits, saturating at 999
  assign st_sum  = {4'd0, status_value} * 14'd10 + {10'd0, data_byte[3:0]};
  assign rem_dec   = body_remaining - 1'b1;
  assign chunk_dec = chunk_size - 1'b1;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = data_byte[3:0];
    if (is_digit(data_byte)) hex_d = data_byte[3:0];
    else if (to_lower(data_byte) >= 8'h61 && to_lower(data_byte) <= 8'h66)
      hex_d = data_byte[3:0] + 4'd9;
    else hex_ok = 1'b0;
  end

  always_comb begin
    phase_next              = phase;
    terminator_window_next  = terminator_window;
    header_count_next       = header_count;
    scan_next               = scan;
    status_value_next       = status_value;
    status_digits_done_next = status_digits_done;
    body_remaining_next     = body_remaining;
    chunk_size_next         = chunk_size;
    hex_active_next         = hex_active;
    crlf_skip_next          = crlf_skip;
    res_en     = 1'b0;
    res_kind   = KIND_BODY;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    res_status = status_value;
    res_err    = ERR_NONE;
    st_end     = 10'd0;
    if (cmd_t'(command) == CMD_RESTART) begin
      phase_next              = PH_HEADER;
      terminator_window_next  = '0;
      header_count_next       = '0;
      scan_next               = SCAN_RESET;
      status_value_next       = '0;
      status_digits_done_next = 1'b0;
      body_remaining_next     = '0;
      chunk_size_next         = '0;
      hex_active_next         = 1'b1;
      crlf_skip_next          = '0;
    end else if (cmd_t'(command) == CMD_NONE || phase == PH_END) begin
      // nothing to do
    end else if (cmd_t'(command) == CMD_CLOSE) begin
      phase_next = PH_END;
      res_en     = 1'b1;
      if (phase == PH_HEADER) begin
        res_kind   = KIND_FAIL;
        res_status = 10'd0;
        res_err    = ERR_CLOSED_HDR;
      end else if (phase == PH_COUNTED || phase == PH_TO_CLOSE) begin
        res_kind = KIND_OK;
      end else begin
        res_kind = KIND_FAIL;
        res_err  = ERR_CLOSED_CHUNK;
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          header_count_next      = header_count + 1'b1;
          terminator_window_next = {terminator_window[23:0], data_byte};
          scan_next              = scan_out;
          if (cl_digit_en) body_remaining_next = dec_val;
          // status digits start at byte offset 9
          if (header_count >= 17'd9 && !status_digits_done) begin
            if (is_digit(data_byte))
              status_value_next = (st_sum > 14'd999) ? 10'd999 : st_sum[9:0];
            else status_digits_done_next = 1'b1;
          end
          if (terminator_window_next == TERMINATOR) begin
            st_end            = (header_count >= 17'd12) ? status_value_next : 10'd0;
            status_value_next = st_end;
            res_status        = st_end;
            if (st_end >= 10'd300 && st_end < 10'd400) begin
              phase_next = PH_END;
              res_en     = 1'b1;
              res_kind   = KIND_FAIL;
              res_err    = scan_next.found_flags[0] ? ERR_REDIRECT : ERR_NO_LOCATION;
            end else if (st_end < 10'd200 || st_end >= 10'd300) begin
              phase_next = PH_END;
              res_en     = 1'b1;
              res_kind   = KIND_FAIL;
              res_err    = ERR_STATUS;
            end else if (scan_next.is_chunked) begin
              phase_next      = PH_SIZE;
              chunk_size_next = '0;
              hex_active_next = 1'b1;
            end else if (scan_next.found_flags[2] &&
                         !(scan_next.length_negative && body_remaining_next != '0)) begin
              if (body_remaining_next == '0) begin
                phase_next = PH_END;
                res_en     = 1'b1;
                res_kind   = KIND_OK;
              end else begin
                phase_next = PH_COUNTED;
              end
            end else begin
              phase_next = PH_TO_CLOSE;
            end
          end else if (header_count_next > limit) begin
            phase_next = PH_END;
            res_en     = 1'b1;
            res_kind   = KIND_FAIL;
            res_status = 10'd0;
            res_err    = ERR_HDR_LONG;
          end
        end
        PH_COUNTED: begin
          body_remaining_next = rem_dec;
          res_en   = 1'b1;
          res_byte = data_byte;
          if (rem_dec == '0) begin
            phase_next = PH_END;
            res_last   = 1'b1;
          end
        end
        PH_TO_CLOSE: begin
          res_en   = 1'b1;
          res_byte = data_byte;
        end
        PH_SIZE: begin
          if (data_byte == CH_LF) begin
            if (chunk_size == '0) begin
              phase_next = PH_END;
              res_en     = 1'b1;
              res_kind   = KIND_OK;
            end else begin
              phase_next = PH_DATA;
            end
          end else if (hex_active) begin
            if (!hex_ok) hex_active_next = 1'b0;
            else if (chunk_size[LENGTH_BITS-1 -: 4] != 4'd0) chunk_size_next = LEN_MAX;
            else chunk_size_next = {chunk_size[LENGTH_BITS-5:0], hex_d};
          end
        end
        PH_DATA: begin
          chunk_size_next = chunk_dec;
          if (chunk_dec == '0) begin
            phase_next     = PH_SKIP;
            crlf_skip_next = 2'd2;
          end
          res_en   = 1'b1;
          res_byte = data_byte;
        end
        PH_SKIP: begin
          crlf_skip_next = (crlf_skip > 2'd0) ? crlf_skip - 2'd1 : crlf_skip;
          if (crlf_skip_next == 2'd0) begin
            phase_next      = PH_SIZE;
            chunk_size_next = '0;
            hex_active_next = 1'b1;
          end
        end
        default: phase_next = PH_END;
      endcase
    end
  end

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      terminator_window  <= '0;
      header_count       <= '0;
      scan               <= SCAN_RESET;
      status_value       <= '0;
      status_digits_done <= 1'b0;
      body_remaining     <= '0;
      chunk_size         <= '0;
      hex_active         <= 1'b1;
      crlf_skip          <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      terminator_window  <= terminator_window_next;
      header_count       <= header_count_next;
      scan               <= scan_next;
      status_value       <= status_value_next;
      status_digits_done <= status_digits_done_next;
      body_remaining     <= body_remaining_next;
      chunk_size         <= chunk_size_next;
      hex_active         <= hex_active_next;
      crlf_skip          <= crlf_skip_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_en;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_en) begin
      out_kind    <= res_kind;
      body_byte   <= res_byte;
      last_byte   <= res_last;
      status_code <= res_status;
      error_code  <= res_err;
    end
  end

  a_last_is_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> out_kind == KIND_BODY)
    else $error("last_byte on a non-body result");

  a_err_only_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> out_kind == KIND_FAIL)
    else $error("error code on a non-failure result");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_t'(command) == CMD_RESTART |=> phase == PH_HEADER && !out_valid)
    else $error("restart did not return to header phase");

  a_end_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_END |=> !out_valid)
    else $error("result produced after end of response");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the http response body deframer: header scan, status and redirect
// verdicts, chunked, counted and close-delimited bodies, header limit register
// ----------------------------------------------------------------------------
module tb_top;
  import hdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] ADDR_HEADER_LIMIT = 3'd0;
  localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_DATA;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  body_byte;
  logic        last_byte;
  logic [9:0]  status_code;
  logic [2:0]  error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  http_response_body_deframer dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // one pending transfer: command plus byte
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] b;
  } byte_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] b;
    logic       last;
    logic [9:0] status;
    err_t       err;
  } verdict_t;

  byte_item_t pending_bytes[$];
  verdict_t   expected_out[$];

  int cycle_count = 0;
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_body = 0;
  int n_ok = 0;
  int n_fail = 0;
  bit rx_hold_req = 1'b0;   // ask receiver for a long hold-off

  // ---------------------------------------------------------------- predictor
  logic [16:0] lim_reg;
  phase_t      ph;
  logic [31:0] term_win;
  logic [16:0] hdr_cnt;
  logic        line_start;
  logic [4:0]  name_pos;
  logic [2:0]  name_cand;
  vstate_t     vstate;
  logic [2:0]  found;
  logic        chunked;
  logic [2:0]  chk_pos;
  logic [9:0]  status_acc;
  logic        status_done;
  logic [31:0] remaining;
  logic [31:0] csize;
  logic        hex_on;
  logic [1:0]  skip_cnt;
  logic        len_neg;

  function automatic logic [7:0] name_char(int k, int p);
    string s;
    s = (k == 0) ? "location" : (k == 1) ? "transfer-encoding" : "content-length";
    return s[p];
  endfunction

  function automatic int name_len(int k);
    return (k == 0) ? 8 : (k == 1) ? 17 : 14;
  endfunction

  function automatic logic [31:0] dec_push(logic [31:0] v, logic [7:0] d);
    logic [35:0] wide;
    wide = v * 36'd10 + d;
    return (wide > LEN_SAT) ? LEN_SAT : wide[31:0];
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    ph = PH_HEADER; term_win = 0; hdr_cnt = 0; line_start = 1; name_pos = 0;
    name_cand = 3'b111; vstate = VS_IDLE; found = 0; chunked = 0; chk_pos = 0;
    status_acc = 0; status_done = 0; remaining = 0; csize = 0; hex_on = 1;
    skip_cnt = 0; len_neg = 0;
  endtask

  task automatic push_verdict(kind_t k, logic [7:0] b, logic l, logic [9:0] s, err_t e);
    verdict_t v;
    v.kind = k; v.b = b; v.last = l; v.status = s; v.err = e;
    expected_out.push_back(v);
  endtask

  // scanner for one header byte
  task automatic scan_byte(logic [7:0] b);
    logic [7:0] lb;
    logic       dig;
    logic [2:0] keep;
    int         hit;
    int         nv;
    lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    dig = (b >= "0" && b <= "9");
    if (hdr_cnt >= 10 && !status_done) begin
      if (dig) begin
        nv = status_acc * 10 + (b - "0");
        status_acc = (nv > 999) ? 10'd999 : nv[9:0];
      end else begin
        status_done = 1;
      end
    end
    if (b == CH_LF) begin
      line_start = 1; name_cand = 0; vstate = VS_IDLE;
      return;
    end
    if (line_start) begin
      line_start = 0; name_cand = 3'b111; name_pos = 0;
    end
    if (name_cand != 0) begin
      keep = 0; hit = -1;
      for (int k = 0; k < 3; k++) begin
        if (!name_cand[k]) continue;
        if (name_pos < name_len(k)) begin
          if (lb == name_char(k, name_pos)) keep[k] = 1'b1;
        end else if (name_pos == name_len(k) && b == ":") begin
          hit = k;
        end
      end
      if (hit >= 0) begin
        name_cand = 0;
        if (!found[hit]) begin
          found[hit] = 1'b1;
          vstate = (hit == 1) ? VS_TE_BLANK : (hit == 2) ? VS_CL_BLANK : VS_IDLE;
        end
      end else begin
        name_cand = keep;
      end
      if (name_pos < 31) name_pos++;
      return;
    end
    // transfer-encoding blank falls into matching on the same byte
    if (vstate == VS_TE_BLANK) begin
      if (b == " " || b == 8'h09) return;
      chk_pos = 0; vstate = VS_TE_MATCH;
    end
    case (vstate)
      VS_TE_MATCH: begin
        if (chk_pos < 7 && lb == CHUNKED[chk_pos]) begin
          chk_pos++;
          if (chk_pos == 7) begin
            chunked = 1; vstate = VS_IDLE;
          end
        end else begin
          vstate = VS_IDLE;
        end
      end
      VS_CL_BLANK: begin
        if (b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C) ;
        else if (b == "+") vstate = VS_CL_DIGITS;
        else if (b == "-") begin
          len_neg = 1; vstate = VS_CL_DIGITS;
        end else if (dig) begin
          remaining = dec_push(remaining, b - "0"); vstate = VS_CL_DIGITS;
        end else vstate = VS_IDLE;
      end
      VS_CL_DIGITS: begin
        if (dig) remaining = dec_push(remaining, b - "0");
        else vstate = VS_IDLE;
      end
      default: vstate = VS_IDLE;
    endcase
  endtask

  task automatic finish_headers();
    logic [9:0] st;
    st = (hdr_cnt > 12) ? status_acc : 10'd0;
    status_acc = st;
    if (st >= 300 && st < 400) begin
      ph = PH_END;
      push_verdict(KIND_FAIL, 0, 0, st, found[0] ? ERR_REDIRECT : ERR_NO_LOCATION);
    end else if (st < 200 || st >= 300) begin
      ph = PH_END;
      push_verdict(KIND_FAIL, 0, 0, st, ERR_STATUS);
    end else if (chunked) begin
      ph = PH_SIZE; csize = 0; hex_on = 1;
    end else if (found[2] && !(len_neg && remaining != 0)) begin
      if (remaining == 0) begin
        ph = PH_END;
        push_verdict(KIND_OK, 0, 0, st, ERR_NONE);
      end else ph = PH_COUNTED;
    end else ph = PH_TO_CLOSE;
  endtask

  // predicts the result, if any, of one accepted transfer
  task automatic predict_deframe(byte_item_t it);
    logic [16:0] lim;
    phase_t      p;
    int          h;
    lim = (lim_reg > LIMIT_MAX) ? LIMIT_MAX : lim_reg;
    if (it.cmd == CMD_RESTART) begin
      clear_parser();
      return;
    end
    if (it.cmd == CMD_NONE || ph == PH_END) return;
    if (it.cmd == CMD_CLOSE) begin
      p = ph; ph = PH_END;
      if (p == PH_HEADER) push_verdict(KIND_FAIL, 0, 0, 0, ERR_CLOSED_HDR);
      else if (p == PH_COUNTED || p == PH_TO_CLOSE)
        push_verdict(KIND_OK, 0, 0, status_acc, ERR_NONE);
      else push_verdict(KIND_FAIL, 0, 0, status_acc, ERR_CLOSED_CHUNK);
      return;
    end
    case (ph)
      PH_HEADER: begin
        hdr_cnt++;
        term_win = {term_win[23:0], it.b};
        scan_byte(it.b);
        if (term_win == TERMINATOR) finish_headers();
        else if (hdr_cnt > lim) begin
          ph = PH_END;
          push_verdict(KIND_FAIL, 0, 0, 0, ERR_HDR_LONG);
        end
      end
      PH_COUNTED: begin
        remaining--;
        if (remaining == 0) begin
          ph = PH_END;
          push_verdict(KIND_BODY, it.b, 1, status_acc, ERR_NONE);
        end else push_verdict(KIND_BODY, it.b, 0, status_acc, ERR_NONE);
      end
      PH_TO_CLOSE: push_verdict(KIND_BODY, it.b, 0, status_acc, ERR_NONE);
      PH_SIZE: begin
        if (it.b == CH_LF) begin
          if (csize == 0) begin
            ph = PH_END;
            push_verdict(KIND_OK, 0, 0, status_acc, ERR_NONE);
          end else ph = PH_DATA;
        end else if (hex_on) begin
          h = hex_digit(it.b);
          if (h < 0) hex_on = 0;
          else if (csize > (LEN_SAT >> 4)) csize = LEN_SAT;
          else csize = {csize[27:0], 4'(h)};
        end
      end
      PH_DATA: begin
        csize--;
        if (csize == 0) begin
          ph = PH_SKIP; skip_cnt = 2;
        end
        push_verdict(KIND_BODY, it.b, 0, status_acc, ERR_NONE);
      end
      PH_SKIP: begin
        if (skip_cnt > 0) skip_cnt--;
        if (skip_cnt == 0) begin
          ph = PH_SIZE; csize = 0; hex_on = 1;
        end
      end
      default: ph = PH_END;
    endcase
  endtask

  // ------------------------------------------------------------------- driver
  int tx_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_deframe('{cmd: cmd_t'(command), b: data_byte});
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          byte_item_t nx;
          nx = pending_bytes.pop_front();
          in_valid <= 1'b1;
          command <= nx.cmd;
          data_byte <= nx.b;
          tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  int rx_gap = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        verdict_t got;
        got = '{kind: kind_t'(out_kind), b: body_byte, last: last_byte,
                status: status_code, err: err_t'(error_code)};
        n_seen++;
        case (got.kind)
          KIND_BODY: n_body++;
          KIND_OK:   n_ok++;
          default:   n_fail++;
        endcase
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %p", $time, got);
        end else begin
          verdict_t want;
          want = expected_out.pop_front();
          if (got.kind != want.kind || got.b != want.b || got.last != want.last ||
              got.status != want.status || got.err != want.err) begin
            errors++;
            $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          end
        end
        rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold_req && rx_hold == 0) begin
        rx_hold = 200;
        rx_hold_req = 1'b0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic add_byte(cmd_t c, logic [7:0] b);
    pending_bytes.push_back('{cmd: c, b: b});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(CMD_DATA, s[i]);
  endtask

  task automatic wait_drain();
    while (pending_bytes.size() > 0 || in_valid || expected_out.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [16:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_HEADER_LIMIT; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    lim_reg = v;
  endtask

  function automatic string mixcase(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
    return r;
  endfunction

  // one well-formed response with random content, opened by a restart and ended by a close or a zero-size chunk
  task automatic add_response();
    int mode;
    int st;
    int n;
    int sel;
    add_byte(CMD_RESTART, $urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    st = (sel < 7) ? $urandom_range(200, 299) : (sel == 7) ? $urandom_range(300, 399)
       : $urandom_range(0, 999);
    add_text($sformatf("HTTP/1.1 %0d OK\r\n", st));
    if ($urandom_range(0, 3) == 0) add_text(mixcase("location: /x\r\n"));
    if ($urandom_range(0, 4) == 0) add_text("X-Pad: zz\r\n");
    mode = $urandom_range(0, 2);
    if (mode == 0) begin
      add_text({mixcase("transfer-encoding:"), " ", mixcase("chunked"), "\r\n\r\n"});
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(1, 6);
        add_text($sformatf("%0x%s\r\n", n, $urandom_range(0, 3) == 0 ? ";e=1" : ""));
        repeat (n) add_byte(CMD_DATA, $urandom_range(0, 255));
        add_text("\r\n");
      end
      if ($urandom_range(0, 4) == 0) add_byte(CMD_CLOSE, 0);
      else add_text("0\r\n\r\n");
    end else if (mode == 1) begin
      n = $urandom_range(0, 8);
      add_text($sformatf("%s: %0d\r\n\r\n", mixcase("content-length"), n));
      repeat ($urandom_range(0, n + 2)) add_byte(CMD_DATA, $urandom_range(0, 255));
      add_byte(CMD_CLOSE, 0);
    end else begin
      add_text("Server: t\r\n\r\n");
      repeat ($urandom_range(0, 8)) add_byte(CMD_DATA, $urandom_range(0, 255));
      add_byte(CMD_CLOSE, 0);
    end
  endtask

  initial begin
    lim_reg = LIMIT_MAX;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 200 counted body with signed length, every noise command
    write_limit(17'd1);
    write_limit(17'h1FFFF);   // above range acts as the maximum
    add_text("HTTP/1.1 200 OK\r\nContent-Length: +2\r\n\r\n");
    add_byte(CMD_NONE, 8'hFF);
    add_byte(CMD_DATA, 8'h00);
    add_byte(CMD_DATA, 8'hFF);
    add_byte(CMD_DATA, 8'h55);   // past the counted body
    add_byte(CMD_CLOSE, 0);
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 301 X\r\nLocation: /a\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 302 X\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 404 X\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 2\r\n\r\n");   // single-digit status 2 fails the status check
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 200 OK\r\nContent-Length: 0\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 200 OK\r\nContent-Length: -3\r\n\r\nab");
    add_byte(CMD_CLOSE, 0);
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 99999 OK\r\nContent-Length:99999999999\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\nFFFFFFFFF\r\nab");
    add_byte(CMD_CLOSE, 0);
    add_byte(CMD_RESTART, 0);
    add_text("HTTP/1.1 200 OK\r\nTransfer-Encoding:\tCHUNKED\r\n\r\n2\r\nhi\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    add_byte(CMD_CLOSE, 0);
    add_byte(CMD_RESTART, 0);
    wait_drain();

    // header limit of zero and a limit shorter than the header
    write_limit(17'd0);
    add_byte(CMD_DATA, "H");
    add_byte(CMD_RESTART, 0);
    wait_drain();
    write_limit(17'd20);
    add_text("HTTP/1.1 200 OK\r\nServer: long\r\n\r\n");
    add_byte(CMD_RESTART, 0);
    wait_drain();
    write_limit(17'd65536);

    // receiver holds off while sender fills the block
    rx_hold_req = 1'b1;
    add_text("HTTP/1.1 200 OK\r\n\r\n");
    repeat (12) add_byte(CMD_DATA, $urandom_range(0, 255));
    add_byte(CMD_CLOSE, 0);
    wait_drain();

    // random phase: mostly well-formed responses, some noise
    for (int r = 0; r < 2; r++) begin
      if (r == 1) begin
        wait_drain();
        write_limit($urandom_range(40, 200));
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 10))
          add_byte(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 255));
      end else begin
        add_response();
      end
    end
    wait_drain();
    repeat (20) @(posedge clk);
    $display("sent %0d transfers, checked %0d results: %0d body, %0d ok, %0d failed",
             n_sent, n_seen, n_body, n_ok, n_fail);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end
endmodule
